@@ hw/rtl/wsal_pkg.sv @@
// package for the station address learner
// holds operation, kind and status codes, header constants and the sequencer state type
// no dependencies
package wsal_pkg;

   // default table size
   localparam int TABLE_DEPTH_DEFAULT = 32;

   // field widths
   localparam int ADDR_W   = 48;
   localparam int STATUS_W = 4;
   localparam int COUNT_W  = 6;
   localparam int SLOT_W   = 5;
   localparam int LEN_W    = 12;

   // operation codes
   localparam logic [1:0] OP_FRAME = 2'd0;
   localparam logic [1:0] OP_CLEAR = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   // frame kinds
   localparam logic [1:0] KIND_DATA = 2'd0;
   localparam logic [1:0] KIND_MGMT = 2'd1;

   // header constants
   localparam logic [LEN_W-1:0] MIN_HEADER_LEN = 12'd24;
   localparam int TO_DS_BIT   = 0;
   localparam int FROM_DS_BIT = 1;
   localparam int GROUP_BIT   = 40;

   // result status codes
   localparam logic [STATUS_W-1:0] STAT_IGNORED     = 4'd0;
   localparam logic [STATUS_W-1:0] STAT_SHORT       = 4'd1;
   localparam logic [STATUS_W-1:0] STAT_FOUR_ADDR   = 4'd2;
   localparam logic [STATUS_W-1:0] STAT_OTHER_BSSID = 4'd3;
   localparam logic [STATUS_W-1:0] STAT_GROUP       = 4'd4;
   localparam logic [STATUS_W-1:0] STAT_IS_AP       = 4'd5;
   localparam logic [STATUS_W-1:0] STAT_KNOWN       = 4'd6;
   localparam logic [STATUS_W-1:0] STAT_ADDED       = 4'd7;
   localparam logic [STATUS_W-1:0] STAT_FULL        = 4'd8;
   localparam logic [STATUS_W-1:0] STAT_READ        = 4'd9;
   localparam logic [STATUS_W-1:0] STAT_CLEARED     = 4'd10;

   // sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_SCAN,
      S_READ_DATA,
      S_FINISH
   } state_type;

endpackage

@@ hw/rtl/wsal_ram.sv @@
// generic single-clock ram, one write port and one read port
// read data is registered; no dependencies
module wsal_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 32
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

@@ hw/rtl/wlan_station_address_learner.sv @@
// station address learner: one item at a time; a header is judged in the decide state, then
// the table is scanned one entry per cycle through the ram read port.
// result sits in an output register, so the next item is taken while it waits.
// synchronous active-high reset clears count, target bssid and control; table is not cleared.
// depends on wsal_pkg and wsal_ram
module wlan_station_address_learner
   import wsal_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   // configuration
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [ADDR_W-1:0]   csr_data,
   // items in
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_operation,
   input  logic [1:0]          req_frame_kind,
   input  logic [LEN_W-1:0]    req_frame_length,
   input  logic [7:0]          req_control_flags,
   input  logic [ADDR_W-1:0]   req_address_one,
   input  logic [ADDR_W-1:0]   req_address_two,
   input  logic [ADDR_W-1:0]   req_address_three,
   input  logic [SLOT_W-1:0]   req_read_slot,
   // results out
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [COUNT_W-1:0]  rsp_station_count,
   output logic [ADDR_W-1:0]   rsp_entry_address,
   output logic                rsp_entry_valid
);

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int IDX_W = $clog2(TABLE_DEPTH > 1 ? TABLE_DEPTH : 2);

   state_type state_ff, state_in;

   logic [ADDR_W-1:0]   target_ff;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic                cmp_vld_ff, cmp_vld_in;

   // latched item
   logic [1:0]          op_ff, kind_ff;
   logic [LEN_W-1:0]    len_ff;
   logic [7:0]          flags_ff;
   logic [ADDR_W-1:0]   a1_ff, a2_ff, a3_ff;
   logic [SLOT_W-1:0]   slot_ff;

   // pending result
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [ADDR_W-1:0]   res_entry_ff, res_entry_in;
   logic                res_evalid_ff, res_evalid_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic [ADDR_W-1:0]   rsp_entry_ff, rsp_entry_in;
   logic                rsp_evalid_ff, rsp_evalid_in;

   // ram ports
   logic                ram_we;
   logic [IDX_W-1:0]    ram_waddr, ram_raddr;
   logic [ADDR_W-1:0]   ram_rdata;

   // derived fields
   logic                to_ds, from_ds, req_take;
   logic [ADDR_W-1:0]   bssid, sta;
   logic [CNT_W+SLOT_W-1:0] slot_ext, cnt_ext;
   logic [CNT_W+COUNT_W-1:0] cnt_out_ext;
   logic                slot_ok, scan_issue;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_station_count = rsp_count_ff;
   assign rsp_entry_address = rsp_entry_ff;
   assign rsp_entry_valid   = rsp_evalid_ff;

   // station and bssid picked by the ds bits
   assign to_ds   = flags_ff[TO_DS_BIT];
   assign from_ds = flags_ff[FROM_DS_BIT];
   always_comb begin
      if (to_ds) begin
         bssid = a1_ff;
         sta   = a2_ff;
      end else if (from_ds) begin
         bssid = a2_ff;
         sta   = a1_ff;
      end else begin
         bssid = a3_ff;
         sta   = a2_ff;
      end
   end

   // read slot range check
   assign slot_ext    = {{CNT_W{1'b0}}, slot_ff};
   assign cnt_ext     = {{SLOT_W{1'b0}}, cnt_ff};
   assign slot_ok     = slot_ext < cnt_ext;
   assign cnt_out_ext = {{COUNT_W{1'b0}}, cnt_ff};
   assign scan_issue  = idx_ff < cnt_ff;

   // table ram
   assign ram_raddr = (state_ff == S_SCAN) ? idx_ff[IDX_W-1:0] : slot_ext[IDX_W-1:0];
   assign ram_waddr = cnt_ff[IDX_W-1:0];

   wsal_ram #(
      .WIDTH(ADDR_W),
      .DEPTH(TABLE_DEPTH)
   ) u_table (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(sta),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   // next state and outputs
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      idx_in        = idx_ff;
      cmp_vld_in    = 1'b0;
      res_status_in = res_status_ff;
      res_entry_in  = res_entry_ff;
      res_evalid_in = res_evalid_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_evalid_in = rsp_evalid_ff;
      ram_we        = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            res_entry_in  = '0;
            res_evalid_in = 1'b0;
            idx_in        = '0;
            state_in      = S_FINISH;
            case (op_ff)
               OP_FRAME: begin
                  if (kind_ff != KIND_DATA && kind_ff != KIND_MGMT) begin
                     res_status_in = STAT_IGNORED;
                  end else if (len_ff < MIN_HEADER_LEN) begin
                     res_status_in = STAT_SHORT;
                  end else if (to_ds && from_ds) begin
                     res_status_in = STAT_FOUR_ADDR;
                  end else if (bssid != target_ff) begin
                     res_status_in = STAT_OTHER_BSSID;
                  end else if (sta[GROUP_BIT]) begin
                     res_status_in = STAT_GROUP;
                  end else if (sta == target_ff) begin
                     res_status_in = STAT_IS_AP;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
               OP_CLEAR: begin
                  cnt_in        = '0;
                  res_status_in = STAT_CLEARED;
               end
               OP_READ: begin
                  res_status_in = STAT_READ;
                  res_evalid_in = slot_ok;
                  state_in      = S_READ_DATA;
               end
               default: begin
                  res_status_in = STAT_IGNORED;
               end
            endcase
         end
         S_SCAN: begin
            // one read issued and one compare per cycle
            cmp_vld_in = scan_issue;
            if (scan_issue) begin
               idx_in = idx_ff + 1'b1;
            end
            if (cmp_vld_ff && ram_rdata == sta) begin
               cmp_vld_in    = 1'b0;
               res_status_in = STAT_KNOWN;
               state_in      = S_FINISH;
            end else if (!scan_issue && !cmp_vld_ff) begin
               if (cnt_ff < CNT_W'(TABLE_DEPTH)) begin
                  ram_we        = 1'b1;
                  cnt_in        = cnt_ff + 1'b1;
                  res_status_in = STAT_ADDED;
               end else begin
                  res_status_in = STAT_FULL;
               end
               state_in = S_FINISH;
            end
         end
         S_READ_DATA: begin
            res_entry_in = res_evalid_ff ? ram_rdata : '0;
            state_in     = S_FINISH;
         end
         S_FINISH: begin
            // hand the item over once the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_count_in  = cnt_out_ext[COUNT_W-1:0];
               rsp_entry_in  = res_entry_ff;
               rsp_evalid_in = res_evalid_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         target_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            target_ff <= csr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      res_status_ff <= res_status_in;
      res_entry_ff  <= res_entry_in;
      res_evalid_ff <= res_evalid_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_evalid_ff <= rsp_evalid_in;
      if (req_take) begin
         op_ff    <= req_operation;
         kind_ff  <= req_frame_kind;
         len_ff   <= req_frame_length;
         flags_ff <= req_control_flags;
         a1_ff    <= req_address_one;
         a2_ff    <= req_address_two;
         a3_ff    <= req_address_three;
         slot_ff  <= req_read_slot;
      end
   end

endmodule
